// File: hdl/dccc_pkg.sv
// ----------------------------------------------------------------------------
// Dragon coherent cache controller package
// Line states, access kinds, bus requests, snoop replies and controller states
// shared by the cache controller RTL.
// ----------------------------------------------------------------------------
package dccc_pkg;

  // Dragon line states as kept in the tag memory.
  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_E    = 3'd1,
    ST_SC   = 3'd2,
    ST_SM   = 3'd3,
    ST_M    = 3'd4
  } line_state_e;

  // Kind of item on the input stream.
  typedef enum logic [1:0] {
    MODE_PR_RD   = 2'd0,
    MODE_PR_WR   = 2'd1,
    MODE_BUS_RD  = 2'd2,
    MODE_BUS_UPD = 2'd3
  } access_mode_e;

  // Bus transaction the cache issues for a processor access.
  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_BUS_RD  = 2'd1,
    REQ_BUS_UPD = 2'd2
  } bus_request_e;

  // Reply the cache gives to a snooped transaction.
  typedef enum logic [1:0] {
    RPL_NONE   = 2'd0,
    RPL_UPDATE = 2'd1,
    RPL_FLUSH  = 2'd2
  } snoop_reply_e;

  // Controller sequencing.
  typedef enum logic [1:0] {
    CTRL_CLEAR  = 2'd0,
    CTRL_IDLE   = 2'd1,
    CTRL_LOOKUP = 2'd2
  } ctrl_state_e;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned StampWidth = 32;
  localparam int unsigned InDataW    = 72;
  localparam int unsigned OutDataW   = 8;

  // One result item, last field lowest when packed into the output stream.
  typedef struct packed {
    line_state_e  new_line_state;
    snoop_reply_e snoop_reply;
    bus_request_e bus_request;
    logic         hit;
  } result_t;

endpackage

// File: hdl/dragon_coherent_cache_controller.sv
// ----------------------------------------------------------------------------
// Dragon coherent cache controller
// Set-associative line-state tracker for the Dragon protocol with LRU
// replacement by last-use stamp, built around one set-wide tag memory.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one item per access: tuser holds the kind
//   (processor read or write, snooped BusRd or BusUpd), tdata the address,
//   the shared line and the current time stamp. Each item yields exactly one
//   result item on the output stream: hit, bus request, snoop reply and the
//   new Dragon state of the block.
//   Each item is first read as a whole set from the tag memory; then the ways
//   are compared, the LRU victim is picked and the set is written back, which
//   waits while the output register is full. The next item is taken in the
//   cycle after the write, so same-set items never see stale data and no new
//   item is taken before the last one is written back.
//   After reset the controller clears the tag memory, one set per cycle, and
//   takes the first item once every set is cleared.
//   The result sits in an output register; a new item is still accepted while
//   it waits, and the lookup stalls until that register is free again.
//   NUM_SETS and BLOCK_BYTES are powers of two.
// ----------------------------------------------------------------------------
module dragon_coherent_cache_controller #(
  parameter int unsigned NUM_SETS    = 64,
  parameter int unsigned NUM_WAYS    = 4,
  parameter int unsigned BLOCK_BYTES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] address, [32] shared_line, [64:33] access_time, [71:65] zero
  input  logic [dccc_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] hit, [2:1] bus_request, [4:3] snoop_reply, [7:5] new_line_state
  output logic [dccc_pkg::OutDataW-1:0] m_axis_tdata
);
  import dccc_pkg::*;

  localparam int unsigned OffW    = $clog2(BLOCK_BYTES);
  localparam int unsigned SetLog  = $clog2(NUM_SETS);
  localparam int unsigned SetW    = (NUM_SETS > 1) ? SetLog : 1;
  localparam int unsigned TagW    = AddrWidth - OffW - SetLog;
  localparam int unsigned WayLog  = $clog2(NUM_WAYS);
  localparam int unsigned WayW    = (NUM_WAYS > 1) ? WayLog : 1;
  localparam int unsigned TreeN   = 1 << WayLog;

  typedef struct packed {
    logic [TagW-1:0]       tag;
    line_state_e           status;
    logic [StampWidth-1:0] last_use;
  } line_t;

  typedef line_t [NUM_WAYS-1:0] set_row_t;

  // Tag memory, one row per set.
  set_row_t mem_q [NUM_SETS];
  set_row_t rd_row_q;
  set_row_t wr_row;
  logic     rd_en;
  logic     wr_en;
  logic [SetW-1:0] wr_addr;

  ctrl_state_e state_q, state_d;
  logic [SetW-1:0] clr_idx_q, clr_idx_d;

  // Captured item.
  access_mode_e          mode_q;
  logic [SetW-1:0]       set_q;
  logic [TagW-1:0]       tag_q;
  logic                  shared_q;
  logic [StampWidth-1:0] now_q;

  logic [AddrWidth-1:0]  in_addr;
  logic [AddrWidth-1:0]  in_blk;

  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t res;

  logic    in_accept;
  logic    advance;
  logic    out_load;

  logic            hit_found;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] victim_way;
  logic [WayW-1:0] tgt_way;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign advance   = !out_valid_q || m_axis_tready;
  assign in_addr   = s_axis_tdata[AddrWidth-1:0];
  assign in_blk    = in_addr >> OffW;

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    case (state_q)
      CTRL_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == SetW'(NUM_SETS - 1)) begin
          state_d = CTRL_IDLE;
        end
      end
      CTRL_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = CTRL_LOOKUP;
        end
      end
      CTRL_LOOKUP: begin
        if (advance) begin
          state_d = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_CLEAR;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = set_q;
    out_load      = 1'b0;
    case (state_q)
      CTRL_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_q;
      end
      CTRL_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en         = s_axis_tvalid;
      end
      CTRL_LOOKUP: begin
        wr_en    = advance;
        out_load = advance;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q   <= access_mode_e'(s_axis_tuser);
      set_q    <= SetW'(in_blk % NUM_SETS);
      tag_q    <= TagW'(in_blk / NUM_SETS);
      shared_q <= s_axis_tdata[AddrWidth];
      now_q    <= s_axis_tdata[AddrWidth+StampWidth:AddrWidth+1];
    end
  end

  // --------------------------------------------------------------------------
  // Tag memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= mem_q[SetW'(in_blk % NUM_SETS)];
    end
  end

  // --------------------------------------------------------------------------
  // Way lookup and LRU victim
  // --------------------------------------------------------------------------
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    // Scan downward so that the lowest matching way wins.
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_row_q[w].status != ST_NONE && rd_row_q[w].tag == tag_q) begin
        hit_found = 1'b1;
        hit_way   = WayW'(w);
      end
    end
  end

  // Binary tree of compares; the left side holds the lower ways and wins ties.
  always_comb begin
    logic [StampWidth-1:0] node_use [2*TreeN];
    logic [WayW-1:0]       node_way [2*TreeN];
    for (int i = 0; i < 2 * TreeN; i++) begin
      node_use[i] = '1;
      node_way[i] = '0;
    end
    for (int i = 0; i < TreeN; i++) begin
      if (i < NUM_WAYS) begin
        node_use[TreeN+i] = rd_row_q[i].last_use;
      end
      node_way[TreeN+i] = WayW'(i);
    end
    for (int n = TreeN - 1; n >= 1; n--) begin
      if (node_use[2*n+1] < node_use[2*n]) begin
        node_use[n] = node_use[2*n+1];
        node_way[n] = node_way[2*n+1];
      end else begin
        node_use[n] = node_use[2*n];
        node_way[n] = node_way[2*n];
      end
    end
    victim_way = node_way[1];
  end

  // --------------------------------------------------------------------------
  // Dragon state update
  // --------------------------------------------------------------------------
  always_comb begin
    line_state_e cur_st;
    wr_row          = rd_row_q;
    res.hit         = hit_found;
    res.bus_request = REQ_NONE;
    res.snoop_reply = RPL_NONE;
    tgt_way         = hit_found ? hit_way : victim_way;
    cur_st          = rd_row_q[tgt_way].status;
    res.new_line_state = ST_NONE;

    if (state_q == CTRL_CLEAR) begin
      wr_row = '0;
    end else if (mode_q == MODE_PR_RD || mode_q == MODE_PR_WR) begin
      if (!hit_found) begin
        res.bus_request = REQ_BUS_RD;
        if (mode_q == MODE_PR_WR) begin
          res.new_line_state = shared_q ? ST_SM : ST_M;
        end else begin
          res.new_line_state = shared_q ? ST_SC : ST_E;
        end
        wr_row[tgt_way].tag = tag_q;
      end else begin
        res.new_line_state = cur_st;
        if (mode_q == MODE_PR_WR) begin
          if (cur_st == ST_SC || cur_st == ST_SM) begin
            res.bus_request    = REQ_BUS_UPD;
            res.new_line_state = shared_q ? ST_SM : ST_M;
          end else if (cur_st == ST_E) begin
            res.new_line_state = ST_M;
          end
        end
      end
      wr_row[tgt_way].status   = res.new_line_state;
      wr_row[tgt_way].last_use = now_q;
    end else if (hit_found) begin
      res.new_line_state = cur_st;
      if (mode_q == MODE_BUS_RD) begin
        if (cur_st == ST_E) begin
          res.new_line_state = ST_SC;
          res.snoop_reply    = RPL_UPDATE;
        end else if (cur_st == ST_M) begin
          res.new_line_state = ST_SM;
          res.snoop_reply    = RPL_FLUSH;
        end else if (cur_st == ST_SM) begin
          res.snoop_reply    = RPL_FLUSH;
        end
      end else begin
        if (cur_st == ST_SM) begin
          res.new_line_state = ST_SC;
        end else if (cur_st == ST_SC) begin
          res.snoop_reply    = RPL_UPDATE;
        end
      end
      wr_row[tgt_way].status = res.new_line_state;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == CTRL_LOOKUP)
    else $error("accepted item did not enter lookup");

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("tag memory read and write in the same cycle");

  a_result_writes_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> wr_en && wr_addr == set_q)
    else $error("result produced without set write-back");

  a_result_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:5] <= ST_M)
    else $error("result carries an illegal line state");

endmodule
